>>> rtl/core/gss_pkg.sv
`timescale 1ns / 1ps

package gss_pkg;

  // Width of a direction component and of the wide vector registers.
  localparam int BIG_W = 56;
  // Wide operands are fed to the multiplier as a low and a high half.
  localparam int LO_W = 28;
  localparam int DEF_COORD_W = 16;
  localparam logic [7:0] DEF_MAX_STEPS = 8'd50;

  typedef enum logic [1:0] {
    VERDICT_CONT  = 2'd0,
    VERDICT_SEP   = 2'd1,
    VERDICT_HIT   = 2'd2,
    VERDICT_LIMIT = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOTP,
    S_VDA,
    S_VDB,
    S_N,
    S_NDOT,
    S_F1,
    S_F1D,
    S_F2,
    S_F2D,
    S_F3,
    S_OUT
  } state_t;

  // Operation handed to the vector unit.
  typedef struct packed {
    logic is_dot;
    logic negate;
  } vop_t;

  // Next axis index, wrapping after z.
  function automatic logic [1:0] next_axis(input logic [1:0] v);
    logic [1:0] r;
    r = (v == 2'd2) ? 2'd0 : v + 2'd1;
    return r;
  endfunction

endpackage

>>> rtl/core/gss_vec_unit.sv
`timescale 1ns / 1ps

module gss_vec_unit import gss_pkg::*; #(
  parameter int SMALL_W = DEF_COORD_W + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  vop_t                      op,
  input  logic signed [BIG_W-1:0]   big_i   [3],
  input  logic signed [SMALL_W-1:0] small_i [3],
  output logic                      done,
  output logic signed [BIG_W-1:0]   res_o   [3],
  output logic                      dot_pos,
  output logic                      dot_neg
);

  localparam int MOP_W = LO_W + 1;
  localparam int PRD_W = MOP_W + SMALL_W;
  localparam int ACC_W = BIG_W + SMALL_W + 2;

  logic                     busy_r;
  logic                     done_r;
  logic [3:0]               idx_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [BIG_W-1:0]  res_r [3];
  logic                     pos_r;
  logic                     neg_r;

  logic [1:0]               comp;
  logic [1:0]               bi;
  logic [1:0]               si;
  logic                     half;
  logic                     sub;
  logic signed [BIG_W-1:0]  bsel;
  logic signed [MOP_W-1:0]  mop;
  logic signed [PRD_W-1:0]  prod;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     grp_end;
  logic                     last;

  // Cross product: component k is b[k+1]*s[k+2] - b[k+2]*s[k+1].
  // Dot product: sum of b[k]*s[k]. Each term is split into a low and a high half, taken one after the other.
  always_comb begin
    comp = idx_r[3:2];
    half = idx_r[0];
    if (op.is_dot) begin
      bi      = idx_r[2:1];
      si      = idx_r[2:1];
      sub     = 1'b0;
      grp_end = (idx_r == 4'd5);
      last    = (idx_r == 4'd5);
    end else begin
      if (idx_r[1]) begin
        bi = next_axis(next_axis(comp));
        si = next_axis(comp);
      end else begin
        bi = next_axis(comp);
        si = next_axis(next_axis(comp));
      end
      sub     = idx_r[1] ^ op.negate;
      grp_end = (idx_r[1:0] == 2'b11);
      last    = (idx_r == 4'd11);
    end
    bsel = big_i[bi];
    if (half) begin
      mop = MOP_W'($signed(bsel[BIG_W-1:LO_W]));
    end else begin
      mop = $signed({1'b0, bsel[LO_W-1:0]});
    end
    prod = mop * small_i[si];
    if (half) begin
      addend = ACC_W'(prod) <<< LO_W;
    end else begin
      addend = ACC_W'(prod);
    end
    if (sub) begin
      acc_sum = acc_r - addend;
    end else begin
      acc_sum = acc_r + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
      acc_r  <= '0;
      pos_r  <= 1'b0;
      neg_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        idx_r <= idx_r + 4'd1;
        if (grp_end) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_sum;
        end
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (op.is_dot) begin
            neg_r <= acc_sum[ACC_W-1];
            pos_r <= !acc_sum[ACC_W-1] && (acc_sum != '0);
          end
        end
      end else if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        acc_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && grp_end && !op.is_dot) begin
      res_r[comp] <= acc_sum[BIG_W-1:0];
    end
  end

  assign done    = done_r;
  assign res_o   = res_r;
  assign dot_pos = pos_r;
  assign dot_neg = neg_r;

endmodule

>>> rtl/core/gjk_simplex_step_top.sv
`timescale 1ns / 1ps

// One step of a 3-D GJK intersection query per request. The host sends a
// Minkowski-difference support point (start flag set on the first point of a
// query) and receives a verdict plus the next search direction, which is the
// direction for its next support lookup. All arithmetic is exact integer
// arithmetic, so the signs of the dot products are never wrong. The block
// takes one request at a time: in_tready is high only while the sequencer is
// idle. A start point, or a point while no query runs, goes straight to the
// output state and from there into the output register. Every other point
// runs a sequence of dot and cross products on one shared multiply-accumulate
// unit, which the sequencer starts for each product before it picks up the
// result. The slowest step is a tetrahedron step that tests all three new
// faces and then refines to an edge. in_tready comes back in the same cycle
// as the result. The output register holds a finished result until it is
// taken; the sequencer waits for the register to be free, then loads its
// result there and goes idle in the same cycle.
// max_steps at address 0 limits the steps of one query; a value of 0 acts
// like 1. The user must write it only while no request is in flight; the
// block itself does not enforce this.

module gjk_simplex_step_top import gss_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_W
) (
  input  logic          clk,
  input  logic          rst_n,
  // Input channel.
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: point_x [15:0], point_y [31:16], point_z [47:32].
  input  logic [47:0]   in_tdata,
  // tuser: start_req [0].
  input  logic [0:0]    in_tuser,
  // Result channel.
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: dir_x [55:0], dir_y [111:56], dir_z [167:112].
  output logic [167:0]  out_tdata,
  // tuser: verdict [1:0].
  output logic [1:0]    out_tuser,
  // Configuration port.
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = COORD_WIDTH + 1;

  // Control state.
  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [1:0]             size_r, size_nxt;
  logic [7:0]             step_r, step_nxt;
  logic [7:0]             max_steps_r;
  logic                   go_r, go_nxt;
  logic                   tri_r, tri_nxt;
  logic [1:0]             fc_r, fc_nxt;
  logic                   esel_r, esel_nxt;
  verdict_t               verd_r, verd_nxt;
  logic                   zero_r, zero_nxt;
  logic                   out_valid_r;

  // Simplex and working vectors.
  logic signed [CW-1:0]    pts_r [3][3];
  logic signed [CW-1:0]    pts_nxt [3][3];
  logic signed [BIG_W-1:0] dir_r [3], dir_nxt [3];
  logic signed [BIG_W-1:0] n_r [3], n_nxt [3];
  logic signed [BIG_W-1:0] t_r [3], t_nxt [3];
  logic signed [SW-1:0]    p_r [3], p_nxt [3];
  logic signed [SW-1:0]    ao_r [3], ao_nxt [3];
  logic signed [SW-1:0]    ab_r [3], ab_nxt [3];
  logic signed [SW-1:0]    ac_r [3], ac_nxt [3];
  logic signed [SW-1:0]    ad_r [3], ad_nxt [3];
  logic signed [SW-1:0]    e1_r [3], e1_nxt [3];
  logic signed [SW-1:0]    e2_r [3], e2_nxt [3];

  logic signed [BIG_W-1:0] out_dir_r [3];
  verdict_t                out_verd_r;

  // Shared unit connections.
  vop_t                    vop;
  logic signed [BIG_W-1:0] big_v [3];
  logic signed [SW-1:0]    small_v [3];
  logic                    u_done;
  logic signed [BIG_W-1:0] u_res [3];
  logic                    u_pos;
  logic                    u_neg;

  logic signed [SW-1:0]    p_in [3];
  logic signed [SW-1:0]    evec [3];
  logic                    in_acc;
  logic                    cfg_wr;
  logic                    fin_run;

  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    p_in[0] = SW'($signed(in_tdata[CW-1:0]));
    p_in[1] = SW'($signed(in_tdata[16+CW-1:16]));
    p_in[2] = SW'($signed(in_tdata[32+CW-1:32]));
    for (int k = 0; k < 3; k++) begin
      evec[k] = esel_r ? e2_r[k] : e1_r[k];
    end
  end

  // Operand selection for the shared unit, fixed while a state waits on it.
  always_comb begin
    vop = '{is_dot: 1'b1, negate: 1'b0};
    for (int k = 0; k < 3; k++) begin
      big_v[k]   = n_r[k];
      small_v[k] = ao_r[k];
    end
    case (state_r)
      S_DOTP: begin
        for (int k = 0; k < 3; k++) begin
          big_v[k]   = dir_r[k];
          small_v[k] = p_r[k];
        end
      end
      S_VDA: begin
        vop.is_dot = 1'b0;
        for (int k = 0; k < 3; k++) begin
          big_v[k] = BIG_W'(evec[k]);
        end
      end
      S_VDB: begin
        vop.is_dot = 1'b0;
        for (int k = 0; k < 3; k++) begin
          big_v[k]   = t_r[k];
          small_v[k] = evec[k];
        end
      end
      S_N: begin
        vop.is_dot = 1'b0;
        for (int k = 0; k < 3; k++) begin
          big_v[k]   = BIG_W'(e1_r[k]);
          small_v[k] = e2_r[k];
        end
      end
      S_F1: begin
        // Edge normal e1 x n, computed as -(n x e1).
        vop = '{is_dot: 1'b0, negate: 1'b1};
        for (int k = 0; k < 3; k++) begin
          small_v[k] = e1_r[k];
        end
      end
      S_F2: begin
        vop.is_dot = 1'b0;
        for (int k = 0; k < 3; k++) begin
          small_v[k] = e2_r[k];
        end
      end
      S_F1D, S_F2D: begin
        for (int k = 0; k < 3; k++) begin
          big_v[k] = t_r[k];
        end
      end
      default: begin
      end
    endcase
  end

  gss_vec_unit #(
    .SMALL_W (SW)
  ) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (go_r),
    .op      (vop),
    .big_i   (big_v),
    .small_i (small_v),
    .done    (u_done),
    .res_o   (u_res),
    .dot_pos (u_pos),
    .dot_neg (u_neg)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    size_nxt  = size_r;
    step_nxt  = step_r;
    go_nxt    = 1'b0;
    tri_nxt   = tri_r;
    fc_nxt    = fc_r;
    esel_nxt  = esel_r;
    verd_nxt  = verd_r;
    zero_nxt  = zero_r;
    pts_nxt   = pts_r;
    dir_nxt   = dir_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    ao_nxt    = ao_r;
    ab_nxt    = ab_r;
    ac_nxt    = ac_r;
    ad_nxt    = ad_r;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    fin_run   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          for (int k = 0; k < 3; k++) begin
            p_nxt[k]  = p_in[k];
            ao_nxt[k] = -p_in[k];
            ab_nxt[k] = SW'(pts_r[0][k]) - p_in[k];
            ac_nxt[k] = SW'(pts_r[1][k]) - p_in[k];
            ad_nxt[k] = SW'(pts_r[2][k]) - p_in[k];
          end
          verd_nxt = VERDICT_CONT;
          if (in_tuser[0]) begin
            // New query: the first point sits in the second slot.
            for (int k = 0; k < 3; k++) begin
              pts_nxt[0][k] = '0;
              pts_nxt[1][k] = p_in[k][CW-1:0];
              pts_nxt[2][k] = '0;
              dir_nxt[k]    = -BIG_W'(p_in[k]);
            end
            size_nxt  = 2'd1;
            step_nxt  = '0;
            phase_nxt = PH_FIRST;
            zero_nxt  = 1'b0;
            state_nxt = S_OUT;
          end else if (phase_r == PH_IDLE) begin
            // No query running: the point is dropped.
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DOTP;
            go_nxt    = 1'b1;
          end
        end
      end

      S_DOTP: begin
        if (u_done) begin
          if (u_neg) begin
            verd_nxt  = VERDICT_SEP;
            zero_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
            state_nxt = S_OUT;
          end else if (phase_r == PH_FIRST) begin
            e1_nxt    = ac_r;
            esel_nxt  = 1'b0;
            state_nxt = S_VDA;
            go_nxt    = 1'b1;
          end else begin
            e1_nxt    = ab_r;
            e2_nxt    = ac_r;
            tri_nxt   = (size_r == 2'd2);
            fc_nxt    = '0;
            state_nxt = S_N;
            go_nxt    = 1'b1;
          end
        end
      end

      S_VDA: begin
        if (u_done) begin
          t_nxt     = u_res;
          state_nxt = S_VDB;
          go_nxt    = 1'b1;
        end
      end

      S_VDB: begin
        if (u_done) begin
          dir_nxt = u_res;
          if (phase_r == PH_FIRST) begin
            for (int k = 0; k < 3; k++) begin
              pts_nxt[0][k] = p_r[k][CW-1:0];
            end
            size_nxt  = 2'd2;
            phase_nxt = PH_RUN;
            verd_nxt  = VERDICT_CONT;
            zero_nxt  = 1'b0;
            state_nxt = S_OUT;
          end else begin
            fin_run = 1'b1;
          end
        end
      end

      S_N: begin
        if (u_done) begin
          n_nxt     = u_res;
          state_nxt = tri_r ? S_F1 : S_NDOT;
          go_nxt    = 1'b1;
        end
      end

      S_NDOT: begin
        if (u_done) begin
          if (u_pos) begin
            // The origin lies beyond this face: rotate its corners into place.
            if (fc_r == 2'd1) begin
              pts_nxt[0] = pts_r[1];
              pts_nxt[1] = pts_r[2];
            end else if (fc_r == 2'd2) begin
              pts_nxt[1] = pts_r[0];
              pts_nxt[0] = pts_r[2];
            end
            state_nxt = S_F1;
            go_nxt    = 1'b1;
          end else if (fc_r == 2'd2) begin
            // Origin is inside all three new faces.
            verd_nxt  = VERDICT_HIT;
            zero_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
            state_nxt = S_OUT;
          end else begin
            if (fc_r == 2'd0) begin
              e1_nxt = ac_r;
              e2_nxt = ad_r;
            end else begin
              e1_nxt = ad_r;
              e2_nxt = ab_r;
            end
            fc_nxt    = fc_r + 2'd1;
            state_nxt = S_N;
            go_nxt    = 1'b1;
          end
        end
      end

      S_F1: begin
        if (u_done) begin
          t_nxt     = u_res;
          state_nxt = S_F1D;
          go_nxt    = 1'b1;
        end
      end

      S_F1D: begin
        if (u_done) begin
          if (u_pos) begin
            pts_nxt[1] = pts_r[0];
            for (int k = 0; k < 3; k++) begin
              pts_nxt[0][k] = p_r[k][CW-1:0];
            end
            size_nxt  = 2'd2;
            esel_nxt  = 1'b0;
            state_nxt = S_VDA;
          end else begin
            state_nxt = S_F2;
          end
          go_nxt = 1'b1;
        end
      end

      S_F2: begin
        if (u_done) begin
          t_nxt     = u_res;
          state_nxt = S_F2D;
          go_nxt    = 1'b1;
        end
      end

      S_F2D: begin
        if (u_done) begin
          if (u_pos) begin
            for (int k = 0; k < 3; k++) begin
              pts_nxt[0][k] = p_r[k][CW-1:0];
            end
            size_nxt  = 2'd2;
            esel_nxt  = 1'b1;
            state_nxt = S_VDA;
            go_nxt    = 1'b1;
          end else if (tri_r) begin
            state_nxt = S_F3;
            go_nxt    = 1'b1;
          end else begin
            pts_nxt[2] = pts_r[1];
            pts_nxt[1] = pts_r[0];
            for (int k = 0; k < 3; k++) begin
              pts_nxt[0][k] = p_r[k][CW-1:0];
            end
            dir_nxt  = n_r;
            size_nxt = 2'd3;
            fin_run  = 1'b1;
          end
        end
      end

      S_F3: begin
        // Triangle: keep the winding so that the normal faces the origin.
        if (u_done) begin
          if (u_pos) begin
            pts_nxt[2] = pts_r[1];
            pts_nxt[1] = pts_r[0];
            dir_nxt    = n_r;
          end else begin
            pts_nxt[2] = pts_r[0];
            for (int k = 0; k < 3; k++) begin
              dir_nxt[k] = -n_r[k];
            end
          end
          for (int k = 0; k < 3; k++) begin
            pts_nxt[0][k] = p_r[k][CW-1:0];
          end
          size_nxt = 2'd3;
          fin_run  = 1'b1;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of a running step: count it and check the limit.
    if (fin_run) begin
      step_nxt = step_r + 8'd1;
      if (step_nxt >= max_steps_r) begin
        verd_nxt  = VERDICT_LIMIT;
        zero_nxt  = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        verd_nxt = VERDICT_CONT;
        zero_nxt = 1'b0;
      end
      state_nxt = S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      size_r  <= '0;
      step_r  <= '0;
      go_r    <= 1'b0;
      tri_r   <= 1'b0;
      fc_r    <= '0;
      esel_r  <= 1'b0;
      verd_r  <= VERDICT_CONT;
      zero_r  <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pts_r[i][k] <= '0;
        end
        dir_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      step_r  <= step_nxt;
      go_r    <= go_nxt;
      tri_r   <= tri_nxt;
      fc_r    <= fc_nxt;
      esel_r  <= esel_nxt;
      verd_r  <= verd_nxt;
      zero_r  <= zero_nxt;
      pts_r   <= pts_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    n_r  <= n_nxt;
    t_r  <= t_nxt;
    p_r  <= p_nxt;
    ao_r <= ao_nxt;
    ab_r <= ab_nxt;
    ac_r <= ac_nxt;
    ad_r <= ad_nxt;
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
  end

  // Output register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_verd_r <= verd_r;
      for (int k = 0; k < 3; k++) begin
        out_dir_r[k] <= zero_r ? '0 : dir_r[k];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_verd_r;
  assign out_tdata  = {out_dir_r[2], out_dir_r[1], out_dir_r[0]};

  // Configuration port: max_steps is the only register.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= DEF_MAX_STEPS;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      max_steps_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {24'd0, max_steps_r};

endmodule

>>> bench/gss_checker.sv
`timescale 1ns / 1ps

module gss_checker import gss_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [47:0]   in_tdata,
  input  logic [0:0]    in_tuser,
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [167:0]  out_tdata,
  input  logic [1:0]    out_tuser,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  input  logic          cfg_pready,
  output int            fail_count,
  output int            pending_count
);

  typedef struct {
    verdict_t verdict;
    logic [55:0] dx, dy, dz;
  } step_result_t;

  typedef longint vec_t [3];

  step_result_t expected_steps[$];

  vec_t corner [3];
  int unsigned hull_size;
  vec_t search_dir;
  phase_t phase;
  int unsigned steps_taken;
  logic [7:0] step_limit;

  assign pending_count = expected_steps.size();

  function automatic vec_t vsub(vec_t p, vec_t q);
    vec_t r;
    for (int i = 0; i < 3; i++) r[i] = p[i] - q[i];
    return r;
  endfunction

  function automatic vec_t vneg(vec_t p);
    vec_t r;
    for (int i = 0; i < 3; i++) r[i] = -p[i];
    return r;
  endfunction

  function automatic vec_t vcross(vec_t p, vec_t q);
    vec_t r;
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
    return r;
  endfunction

  function automatic vec_t vdcross(vec_t p, vec_t q);
    return vcross(vcross(p, q), p);
  endfunction

  // Exact sign with 128-bit accumulation; the magnitudes fit easily.
  function automatic int dot_sign(vec_t p, vec_t q);
    logic signed [127:0] acc;
    acc = 0;
    for (int i = 0; i < 3; i++)
      acc += 128'(signed'(p[i])) * 128'(signed'(q[i]));
    return (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
  endfunction

  function automatic void face_refine(vec_t a, vec_t ao, vec_t ab, vec_t ac, vec_t abc);
    if (dot_sign(vcross(ab, abc), ao) > 0) begin
      corner[1] = corner[0];
      corner[0] = a;
      search_dir = vdcross(ab, ao);
      hull_size = 2;
    end else if (dot_sign(vcross(abc, ac), ao) > 0) begin
      corner[0] = a;
      search_dir = vdcross(ac, ao);
      hull_size = 2;
    end else begin
      corner[2] = corner[1];
      corner[1] = corner[0];
      corner[0] = a;
      search_dir = abc;
      hull_size = 3;
    end
  endfunction

  function automatic void triangle_step(vec_t a);
    vec_t ao, ab, ac, abc;
    ao = vneg(a);
    ab = vsub(corner[0], a);
    ac = vsub(corner[1], a);
    abc = vcross(ab, ac);
    if (dot_sign(vcross(ab, abc), ao) > 0) begin
      corner[1] = corner[0];
      corner[0] = a;
      search_dir = vdcross(ab, ao);
    end else if (dot_sign(vcross(abc, ac), ao) > 0) begin
      corner[0] = a;
      search_dir = vdcross(ac, ao);
    end else begin
      if (dot_sign(abc, ao) > 0) begin
        corner[2] = corner[1];
        corner[1] = corner[0];
        corner[0] = a;
        search_dir = abc;
      end else begin
        corner[2] = corner[0];
        corner[0] = a;
        search_dir = vneg(abc);
      end
      hull_size = 3;
    end
  endfunction

  function automatic bit tetra_step(vec_t a);
    vec_t ao, ab, ac, ad, abc, acd, adb;
    ao = vneg(a);
    ab = vsub(corner[0], a);
    ac = vsub(corner[1], a);
    ad = vsub(corner[2], a);
    abc = vcross(ab, ac);
    acd = vcross(ac, ad);
    adb = vcross(ad, ab);
    if (dot_sign(abc, ao) > 0) begin
      face_refine(a, ao, ab, ac, abc);
      return 0;
    end
    if (dot_sign(acd, ao) > 0) begin
      corner[0] = corner[1];
      corner[1] = corner[2];
      face_refine(a, ao, ac, ad, acd);
      return 0;
    end
    if (dot_sign(adb, ao) > 0) begin
      corner[1] = corner[0];
      corner[0] = corner[2];
      face_refine(a, ao, ad, ab, adb);
      return 0;
    end
    return 1;
  endfunction

  // Advances the query by one support point and returns the answer.
  function automatic step_result_t predict_step(bit start, logic [47:0] data);
    step_result_t res;
    vec_t pt, dir;
    bit hit;
    for (int i = 0; i < 3; i++) pt[i] = longint'(signed'(data[16*i +: 16]));
    dir = '{0, 0, 0};
    res.verdict = VERDICT_CONT;
    if (start) begin
      corner[0] = '{0, 0, 0};
      corner[1] = pt;
      corner[2] = '{0, 0, 0};
      search_dir = vneg(pt);
      hull_size = 1;
      steps_taken = 0;
      phase = PH_FIRST;
      dir = search_dir;
    end else if (phase == PH_FIRST) begin
      if (dot_sign(search_dir, pt) < 0) begin
        res.verdict = VERDICT_SEP;
        phase = PH_IDLE;
      end else begin
        search_dir = vdcross(vsub(corner[1], pt), vneg(pt));
        corner[0] = pt;
        hull_size = 2;
        phase = PH_RUN;
        dir = search_dir;
      end
    end else if (phase == PH_RUN) begin
      hit = 0;
      if (dot_sign(search_dir, pt) < 0) begin
        res.verdict = VERDICT_SEP;
      end else begin
        if (hull_size == 2) triangle_step(pt);
        else if (hull_size == 3) hit = tetra_step(pt);
        if (hit) begin
          res.verdict = VERDICT_HIT;
        end else begin
          steps_taken = (steps_taken + 1) & 8'hFF;
          if (steps_taken >= step_limit) res.verdict = VERDICT_LIMIT;
          else dir = search_dir;
        end
      end
      if (res.verdict != VERDICT_CONT) phase = PH_IDLE;
    end
    res.dx = dir[0][55:0];
    res.dy = dir[1][55:0];
    res.dz = dir[2][55:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [55:0] got, logic [55:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      expected_steps.delete();
      for (int i = 0; i < 3; i++) corner[i] = '{0, 0, 0};
      search_dir = '{0, 0, 0};
      hull_size = 0;
      phase = PH_IDLE;
      steps_taken = 0;
      step_limit = DEF_MAX_STEPS;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        step_limit = (cfg_pwdata[7:0] == 8'd0) ? 8'd1 : cfg_pwdata[7:0];
      if (out_tvalid && out_tready) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("result with no request outstanding", 56'(out_tuser), 56'd0);
        end else begin
          want = expected_steps.pop_front();
          if (out_tuser !== want.verdict)
            report_mismatch("verdict", 56'(out_tuser), 56'(want.verdict));
          if (out_tdata[55:0] !== want.dx) report_mismatch("dir_x", out_tdata[55:0], want.dx);
          if (out_tdata[111:56] !== want.dy)
            report_mismatch("dir_y", out_tdata[111:56], want.dy);
          if (out_tdata[167:112] !== want.dz)
            report_mismatch("dir_z", out_tdata[167:112], want.dz);
        end
      end
      if (in_tvalid && in_tready)
        expected_steps.push_back(predict_step(in_tuser[0], in_tdata));
    end
  end

  initial fail_count = 0;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gss_pkg::*;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [47:0]   in_tdata;
  logic [0:0]    in_tuser;
  logic          out_tvalid;
  logic          out_tready;
  logic [167:0]  out_tdata;
  logic [1:0]    out_tuser;
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [2:0]    cfg_paddr;
  logic [31:0]   cfg_pwdata;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;
  int            fail_count;
  int            pending_count;

  // Idle percentages of the two sides; changed between phases.
  int unsigned   send_idle_pct;
  int unsigned   take_idle_pct;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit            hold_results;
  longint        cycle_count;

  gjk_simplex_step_top dut (.*);

  gss_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous bound: every step of the slowest kind, every stall, many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls at random, and for a long run when the stimulus asks.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_results) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic cfg_write(logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= {$urandom} & 32'hFFFF_FF00 | value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request and holds it until the block takes it, idling first at random.
  // The block is never ready in the cycle after an accept, so the closing idle cycle
  // costs no throughput.
  task automatic send_point(bit start, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= start;
    in_tdata <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected result is in, then lets the sequencer settle.
  task automatic drain;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(20)) - 16'd10;
      default: return 16'($urandom);
    endcase
  endfunction

  // A query: a start point, then random points, now and then with a new start,
  // so the simplex may grow through segment, triangle and tetrahedron.
  task automatic run_query(int unsigned len, bit wild);
    logic [15:0] c [3];
    for (int i = 0; i < 3; i++) c[i] = rand_coord();
    send_point(1'b1, c[0], c[1], c[2]);
    for (int n = 1; n < len; n++) begin
      for (int i = 0; i < 3; i++) c[i] = wild ? rand_coord() : 16'($urandom_range(4000)) - 16'd2000;
      send_point($urandom_range(40) == 0, c[0], c[1], c[2]);
    end
  endtask

  int unsigned sent;

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_results = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, ignored idle points, restart, separation,
    // zero dot product, and a step limit of zero.
    send_point(1'b0, 16'h1234, 16'h8000, 16'h7FFF);
    send_point(1'b1, 16'h8000, 16'h8000, 16'h8000);
    send_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
    send_point(1'b1, 16'd10, 16'd0, 16'd0);
    send_point(1'b0, 16'd0, 16'd5, 16'd0);
    send_point(1'b1, 16'd10, 16'd0, 16'd0);
    send_point(1'b0, -16'd10, 16'd0, 16'd0);
    send_point(1'b0, 16'd0, -16'd10, 16'd0);
    send_point(1'b0, 16'd0, 16'd10, 16'd0);
    send_point(1'b0, 16'd0, 16'd0, 16'd10);
    send_point(1'b0, 16'd0, 16'd0, -16'd10);
    send_point(1'b1, 16'd5, 16'd5, 16'd5);
    send_point(1'b1, 16'd3, 16'd0, 16'd0);
    send_point(1'b0, 16'd20, 16'd0, 16'd0);
    send_point(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    cfg_write(8'd0);
    send_point(1'b1, 16'd10, 16'd0, 16'd0);
    send_point(1'b0, -16'd10, 16'd1, 16'd0);
    send_point(1'b0, 16'd0, 16'd0, 16'd0);
    drain();
    cfg_write(8'd255);

    // Long receiver hold-off while the sender keeps offering requests.
    fork
      begin
        hold_results = 1;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end
      run_query(6, 0);
    join
    drain();

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : ((ph == 1) ? 53 : 0);
      take_idle_pct = (ph == 0) ? 53 : ((ph == 1) ? 35 : 0);
      cfg_write((ph == 0) ? 8'd1 : ((ph == 1) ? 8'd4 : 8'($urandom_range(255, 2))));
      for (int q = 0; q < 52; q++) begin
        run_query($urandom_range(8, 2), $urandom_range(4) == 0);
        if ($urandom_range(10) == 0) send_point(1'b0, rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    // Read back the register once; the value is not checked.
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/gss_pkg.sv
rtl/core/gss_vec_unit.sv
rtl/core/gjk_simplex_step_top.sv
bench/gss_checker.sv
bench/tb_top.sv
